// ===== rtl/tvp_pkg.sv =====
// Shared types and constants for the trapezoidal velocity profiler.
// No dependencies; imported by every module of the block.
package tvp_pkg;

	localparam int unsigned PosW   = 32;  // signed Q16.16 positions and velocity
	localparam int unsigned ErrW   = PosW + 1;
	localparam int unsigned LimW   = 31;  // unsigned Q15.16 magnitudes
	localparam int unsigned TimeW  = 32;
	localparam int unsigned ProdW  = 64;
	localparam int unsigned StepW  = 47;  // (accel * dt) >> 16
	localparam int unsigned FracW  = 16;
	localparam int unsigned SumW   = StepW + 2;

	// Operand pairs for the shared multiplier
	localparam logic [1:0] MSEL_VV = 2'd0;  // |v| * |v|
	localparam logic [1:0] MSEL_EA = 2'd1;  // |err| * accel
	localparam logic [1:0] MSEL_AD = 2'd2;  // accel * dt

	typedef struct packed {
		logic [1:0] mul_sel;
		logic       cap_vv;
		logic       cap_brake;
		logic       do_sum;
		logic       do_out;
		logic       busy;
	} ctrl_t;

endpackage

// ===== rtl/tvp_mul.sv =====
// Shared 32x32 unsigned multiplier with operand select and registered product.
// Depends on tvp_pkg for widths and select codes.
module tvp_mul (
	input  logic                        clk,
	input  logic [1:0]                  sel,
	input  logic [tvp_pkg::PosW-1:0]    abs_v,
	input  logic [tvp_pkg::PosW-1:0]    abs_e,
	input  logic [tvp_pkg::LimW-1:0]    accel,
	input  logic [tvp_pkg::TimeW-1:0]   dt,
	output logic [tvp_pkg::ProdW-1:0]   prod
);
	import tvp_pkg::*;

	logic [31:0]      op_a;
	logic [31:0]      op_b;
	logic [ProdW-1:0] prod_q;

	always_comb begin
		unique case (sel)
			MSEL_VV: begin
				op_a = abs_v;
				op_b = abs_v;
			end
			MSEL_EA: begin
				op_a = abs_e;
				op_b = {1'b0, accel};
			end
			MSEL_AD: begin
				op_a = {1'b0, accel};
				op_b = dt;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(op_a) * ProdW'(op_b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/tvp_ctrl.sv =====
// Sequencer that steps one item through the shared multiplier.
// Depends on tvp_pkg for the control struct and select codes.
module tvp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_block,
	output tvp_pkg::ctrl_t ctrl
);
	import tvp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_VV   = 3'd1;
	localparam logic [2:0] ST_EA   = 3'd2;
	localparam logic [2:0] ST_AD   = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d        = state_q;
		ctrl.mul_sel   = MSEL_VV;
		ctrl.cap_vv    = 1'b0;
		ctrl.cap_brake = 1'b0;
		ctrl.do_sum    = 1'b0;
		ctrl.do_out    = 1'b0;
		ctrl.busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
				if (in_fire) state_d = ST_VV;
			end
			ST_VV: begin
				ctrl.mul_sel = MSEL_VV;
				state_d      = ST_EA;
			end
			ST_EA: begin
				ctrl.mul_sel = MSEL_EA;
				ctrl.cap_vv  = 1'b1;
				state_d      = ST_AD;
			end
			ST_AD: begin
				ctrl.mul_sel   = MSEL_AD;
				ctrl.cap_brake = 1'b1;
				state_d        = ST_SUM;
			end
			ST_SUM: begin
				ctrl.do_sum = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_block) begin
					ctrl.do_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/trapezoidal_velocity_profiler_unit.sv =====
// Top level of the trapezoidal velocity profiler: registers, datapath, assertions.
// Depends on tvp_pkg, tvp_mul and tvp_ctrl.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   in      | in_valid / in_stall     | position_now, position_goal, speed_limit, time_now
//   out     | out_valid / out_stall   | velocity_cmd
//   cfg     | cfg_valid / cfg_ready   | cfg_data (max_accel)
//
// The result is built in steps after the input transfer: three passes through the one
// shared 32x32 multiplier, a sum step and the clamp into the output register.
// No new item is taken before the current one has finished its last step.
// A new item is taken only while the sequencer is idle; a waiting result does not block it.
// Reset clears the stored time, the stored velocity and max_accel; there is no clear pass.
// A stalled result holds the sequencer in its last step until the output register frees.
module trapezoidal_velocity_profiler_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tvp_pkg::LimW-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tvp_pkg::PosW-1:0]   position_now,
	input  logic signed [tvp_pkg::PosW-1:0]   position_goal,
	input  logic [tvp_pkg::LimW-1:0]          speed_limit,
	input  logic [tvp_pkg::TimeW-1:0]         time_now,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tvp_pkg::PosW-1:0]   velocity_cmd
);
	import tvp_pkg::*;

	ctrl_t              ctrl;
	logic               in_fire;
	logic               out_block;

	logic [LimW-1:0]    accel_q;
	logic [TimeW-1:0]   last_time_q;
	logic [PosW-1:0]    last_vel_q;
	logic [ErrW-1:0]    err_q;
	logic [LimW-1:0]    limit_q;
	logic [TimeW-1:0]   dt_q;
	logic [2*LimW-1:0]  vv_q;
	logic               brake_q;
	logic [SumW-1:0]    sum_q;
	logic [PosW-1:0]    out_q;
	logic               out_valid_q;

	logic [PosW-1:0]    abs_v;
	logic [ErrW-1:0]    err_neg;
	logic [PosW-1:0]    abs_e;
	logic [ProdW-1:0]   prod;
	logic               err_pos;
	logic               v_pos;
	logic               step_neg;
	logic [SumW-1:0]    v_ext;
	logic [SumW-1:0]    step_ext;
	logic [SumW-1:0]    lim_ext;
	logic [SumW-1:0]    lim_neg;
	logic [PosW-1:0]    clamped;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && !ctrl.busy;
	assign in_stall  = ctrl.busy;
	assign out_block = out_valid_q && out_stall;

	tvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_block (out_block),
		.ctrl      (ctrl)
	);

	// stored velocity never reaches -2^31, so its magnitude fits the word
	assign abs_v   = last_vel_q[PosW-1] ? (~last_vel_q + 1'b1) : last_vel_q;
	assign err_neg = ~err_q + 1'b1;
	assign abs_e   = err_q[ErrW-1] ? err_neg[PosW-1:0] : err_q[PosW-1:0];

	tvp_mul u_mul (
		.clk   (clk),
		.sel   (ctrl.mul_sel),
		.abs_v (abs_v),
		.abs_e (abs_e),
		.accel (accel_q),
		.dt    (dt_q),
		.prod  (prod)
	);

	// zero counts as negative for both the error and the velocity
	assign err_pos  = !err_q[ErrW-1] && (err_q != '0);
	assign v_pos    = !last_vel_q[PosW-1] && (last_vel_q != '0);
	assign step_neg = brake_q ? !err_pos : v_pos;
	assign v_ext    = {{(SumW-PosW){last_vel_q[PosW-1]}}, last_vel_q};
	assign step_ext = {2'b00, prod[FracW+StepW-1:FracW]};

	assign lim_ext = {{(SumW-LimW){1'b0}}, limit_q};
	assign lim_neg = ~lim_ext + 1'b1;

	always_comb begin
		priority if ($signed(sum_q) > $signed(lim_ext)) begin
			clamped = lim_ext[PosW-1:0];
		end else if ($signed(sum_q) < $signed(lim_neg)) begin
			clamped = lim_neg[PosW-1:0];
		end else begin
			clamped = sum_q[PosW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q     <= '0;
			last_time_q <= '0;
			last_vel_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) accel_q <= cfg_data;
			if (in_fire) last_time_q <= time_now;
			if (ctrl.do_out) begin
				last_vel_q  <= clamped;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q   <= {position_goal[PosW-1], position_goal}
			         - {position_now[PosW-1], position_now};
			limit_q <= speed_limit;
			dt_q    <= time_now - last_time_q;
		end
		if (ctrl.cap_vv) vv_q <= prod[2*LimW-1:0];
		// |err| > floor(v*v / 2a) exactly when 2*|err|*a > v*v
		if (ctrl.cap_brake) brake_q <= {prod[ProdW-2:0], 1'b0} > {2'b00, vv_q};
		if (ctrl.do_sum) sum_q <= step_neg ? (v_ext - step_ext) : (v_ext + step_ext);
		if (ctrl.do_out) out_q <= clamped;
	end

	assign out_valid    = out_valid_q;
	assign velocity_cmd = out_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	a_result_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($signed({out_q[PosW-1], out_q}) <= $signed({2'b00, limit_q}))
			&& ($signed({out_q[PosW-1], out_q}) >= -$signed({2'b00, limit_q})))
		else $error("result outside the speed limit");

	a_result_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.do_out))
		else $error("result raised without a finished item");

endmodule
